FILE: rtl/ndg_pkg.sv
package ndg_pkg;

    localparam int COUNT_WIDTH  = 16;
    localparam int AMOUNT_WIDTH = 24;
    localparam int NOTE_KINDS   = 7;
    localparam int KIND_W       = 3;
    localparam int NOTE_W       = 7;

    // reciprocal scale: floor(left * recip >> shift) is the quotient or one below it
    localparam int RECIP_SHIFT = AMOUNT_WIDTH + NOTE_W;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    localparam logic [NOTE_W-1:0] NOTE_VALUE [NOTE_KINDS] = '{
        NOTE_W'(100), NOTE_W'(50), NOTE_W'(20), NOTE_W'(10),
        NOTE_W'(5), NOTE_W'(2), NOTE_W'(1)
    };

    localparam logic [RECIP_W-1:0] NOTE_RECIP [NOTE_KINDS] = '{
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd100),
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd50),
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd20),
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd10),
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd5),
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd2),
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd1)
    };

    localparam logic [1:0] STAT_WD_OK      = 2'd0;
    localparam logic [1:0] STAT_WD_REFUSED = 2'd1;
    localparam logic [1:0] STAT_DEP_OK     = 2'd2;
    localparam logic [1:0] STAT_DEP_SAT    = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MUL    = 5'b00010,
        ST_FIX    = 5'b00100,
        ST_TAKE   = 5'b01000,
        ST_COMMIT = 5'b10000
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic fix;
        logic take;
    } step_ctrl_t;

endpackage

FILE: rtl/ndg_note_step.sv
module ndg_note_step
    import ndg_pkg::*;
(
    input  logic                    clk,
    input  step_ctrl_t              ctrl,
    input  logic [KIND_W-1:0]       kind,
    input  logic [AMOUNT_WIDTH-1:0] amount,
    input  logic [COUNT_WIDTH-1:0]  stock,
    output logic [AMOUNT_WIDTH-1:0] left,
    output logic [COUNT_WIDTH-1:0]  trial
);

    localparam int PROD_W = AMOUNT_WIDTH + RECIP_W;
    localparam int QV_W   = AMOUNT_WIDTH + NOTE_W;
    localparam int SV_W   = COUNT_WIDTH + NOTE_W;

    logic [AMOUNT_WIDTH-1:0] left_reg, left_next;
    logic [AMOUNT_WIDTH-1:0] q_reg, q_next;
    logic [AMOUNT_WIDTH-1:0] r_reg, r_next;

    logic [NOTE_W-1:0]       value;
    logic [RECIP_W-1:0]      recip;
    logic [PROD_W-1:0]       prod;
    logic [QV_W-1:0]         qv;
    logic [AMOUNT_WIDTH-1:0] r_raw;
    logic [SV_W-1:0]         sv;

    assign value = NOTE_VALUE[kind];
    assign recip = NOTE_RECIP[kind];

    assign prod  = PROD_W'(left_reg) * PROD_W'(recip);
    assign qv    = QV_W'(q_reg) * QV_W'(value);
    assign r_raw = left_reg - qv[AMOUNT_WIDTH-1:0];
    assign sv    = SV_W'(stock) * SV_W'(value);

    always_comb
    begin
        left_next = left_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        trial     = '0;
        if (ctrl.load)
        begin
            left_next = amount;
        end
        if (ctrl.mul)
        begin
            q_next = prod[RECIP_SHIFT +: AMOUNT_WIDTH];
        end
        if (ctrl.fix)
        begin
            // estimate can be one short
            if (r_raw >= AMOUNT_WIDTH'(value))
            begin
                q_next = q_reg + AMOUNT_WIDTH'(1);
                r_next = r_raw - AMOUNT_WIDTH'(value);
            end
            else
            begin
                r_next = r_raw;
            end
        end
        if (ctrl.take)
        begin
            if (q_reg <= stock)
            begin
                trial     = stock - COUNT_WIDTH'(q_reg);
                left_next = r_reg;
            end
            else
            begin
                // stock runs out before the quotient
                trial     = '0;
                left_next = left_reg - AMOUNT_WIDTH'(sv);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg <= left_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
    end

    assign left = left_reg;

endmodule

FILE: rtl/note_dispenser_greedy_unit.sv
// Note dispenser with greedy change making from a limited stock of seven note
// values (100, 50, 20, 10, 5, 2, 1), all counts cleared at reset. Pulse start
// while busy is low to hand in an item. A deposit (cmd high) is applied at
// once: done pulses for one cycle on the next cycle. A withdraw (cmd low)
// walks the note values from largest to smallest through one shared
// quotient unit (reciprocal multiply, correction, take for each value),
// then a commit step: done pulses after the commit, and busy stays high
// until then. The receiver cannot stall: status and the
// stock counts are valid only in the cycle in which done is high, and the
// stock ports keep showing the held counts between items.
module note_dispenser_greedy_unit
    import ndg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    cmd,
    input  logic [AMOUNT_WIDTH-1:0] amount,
    input  logic [COUNT_WIDTH-1:0]  deposit_count_100,
    input  logic [COUNT_WIDTH-1:0]  deposit_count_50,
    input  logic [COUNT_WIDTH-1:0]  deposit_count_20,
    input  logic [COUNT_WIDTH-1:0]  deposit_count_10,
    input  logic [COUNT_WIDTH-1:0]  deposit_count_5,
    input  logic [COUNT_WIDTH-1:0]  deposit_count_2,
    input  logic [COUNT_WIDTH-1:0]  deposit_count_1,
    output logic                    done,
    output logic [1:0]              status,
    output logic [COUNT_WIDTH-1:0]  stock_100,
    output logic [COUNT_WIDTH-1:0]  stock_50,
    output logic [COUNT_WIDTH-1:0]  stock_20,
    output logic [COUNT_WIDTH-1:0]  stock_10,
    output logic [COUNT_WIDTH-1:0]  stock_5,
    output logic [COUNT_WIDTH-1:0]  stock_2,
    output logic [COUNT_WIDTH-1:0]  stock_1
);

    state_t                  state_reg, state_next;
    logic [KIND_W-1:0]       kind_reg, kind_next;
    logic                    done_reg, done_next;
    logic [1:0]              status_reg, status_next;
    logic [COUNT_WIDTH-1:0]  stock_reg [NOTE_KINDS];
    logic [COUNT_WIDTH-1:0]  trial_reg [NOTE_KINDS];

    logic                    accept;
    step_ctrl_t              ctrl;
    logic [AMOUNT_WIDTH-1:0] left;
    logic [COUNT_WIDTH-1:0]  trial;
    logic [COUNT_WIDTH-1:0]  dep_count [NOTE_KINDS];
    logic [COUNT_WIDTH-1:0]  dep_sum [NOTE_KINDS];
    logic [NOTE_KINDS-1:0]   dep_sat;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign dep_count[0] = deposit_count_100;
    assign dep_count[1] = deposit_count_50;
    assign dep_count[2] = deposit_count_20;
    assign dep_count[3] = deposit_count_10;
    assign dep_count[4] = deposit_count_5;
    assign dep_count[5] = deposit_count_2;
    assign dep_count[6] = deposit_count_1;

    always_comb
    begin
        logic [COUNT_WIDTH:0] sum;
        for (int k = 0; k < NOTE_KINDS; k++)
        begin
            sum = {1'b0, stock_reg[k]} + {1'b0, dep_count[k]};
            dep_sat[k] = sum[COUNT_WIDTH];
            dep_sum[k] = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
        end
    end

    assign ctrl.load = accept && !cmd;
    assign ctrl.mul  = (state_reg == ST_MUL);
    assign ctrl.fix  = (state_reg == ST_FIX);
    assign ctrl.take = (state_reg == ST_TAKE);

    ndg_note_step u_step
    (
        .clk    (clk),
        .ctrl   (ctrl),
        .kind   (kind_reg),
        .amount (amount),
        .stock  (stock_reg[kind_reg]),
        .left   (left),
        .trial  (trial)
    );

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd)
                    begin
                        done_next   = 1'b1;
                        status_next = (|dep_sat) ? STAT_DEP_SAT : STAT_DEP_OK;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                        kind_next  = '0;
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                state_next = ST_TAKE;
            end
            ST_TAKE:
            begin
                if (kind_reg == KIND_W'(NOTE_KINDS - 1))
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    state_next = ST_MUL;
                    kind_next  = kind_reg + KIND_W'(1);
                end
            end
            ST_COMMIT:
            begin
                state_next  = ST_IDLE;
                done_next   = 1'b1;
                status_next = (left == '0) ? STAT_WD_OK : STAT_WD_REFUSED;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            kind_reg   <= '0;
            done_reg   <= 1'b0;
            status_reg <= STAT_WD_OK;
            for (int k = 0; k < NOTE_KINDS; k++)
            begin
                stock_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            kind_reg   <= kind_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            if (accept && cmd)
            begin
                for (int k = 0; k < NOTE_KINDS; k++)
                begin
                    stock_reg[k] <= dep_sum[k];
                end
            end
            else if (state_reg == ST_COMMIT && left == '0)
            begin
                for (int k = 0; k < NOTE_KINDS; k++)
                begin
                    stock_reg[k] <= trial_reg[k];
                end
            end
        end
    end

    // trial counts only reach the stock on a covered withdraw
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_TAKE)
        begin
            trial_reg[kind_reg] <= trial;
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign stock_100 = stock_reg[0];
    assign stock_50  = stock_reg[1];
    assign stock_20  = stock_reg[2];
    assign stock_10  = stock_reg[3];
    assign stock_5   = stock_reg[4];
    assign stock_2   = stock_reg[5];
    assign stock_1   = stock_reg[6];

`ifndef SYNTH
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_COMMIT || (start && !busy && cmd)))
        else $error("result strobe without a finished item");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    a_refuse_keeps_stock: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STAT_WD_REFUSED) |->
            ($stable(stock_100) && $stable(stock_50) && $stable(stock_20) &&
             $stable(stock_10) && $stable(stock_5) && $stable(stock_2) &&
             $stable(stock_1)))
        else $error("refused withdraw changed the stock");

    a_deposit_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status[1]) |-> $past(start && !busy && cmd))
        else $error("deposit status without a deposit item");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (kind_reg <= KIND_W'(NOTE_KINDS - 1)))
        else $error("note index out of range");
`endif

endmodule

FILE: dv/tb.sv
module tb;
    import ndg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_WITHDRAW = 1'b0;
    localparam logic CMD_DEPOSIT  = 1'b1;
    localparam int   RANDOM_ITEMS = 800;
    localparam int   CALM_TAIL    = 80;
    localparam int   CYCLE_LIMIT  = 300000;
    localparam int   TAIL_CYCLES  = 40;
    localparam int   DENOM [NOTE_KINDS] = '{100, 50, 20, 10, 5, 2, 1};

    typedef logic [NOTE_KINDS-1:0][COUNT_WIDTH-1:0] note_counts_t;

    typedef struct packed {
        logic                    cmd;
        logic [AMOUNT_WIDTH-1:0] amount;
        note_counts_t            dep;
    } note_request_t;

    typedef struct {
        note_request_t rq;
        bit            wait_empty;
        bit            calm;
    } queued_item_t;

    typedef struct packed {
        logic [1:0]   status;
        note_counts_t stock;
    } note_result_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    note_request_t req_now = '0;
    wire           busy;
    wire           done;
    wire [1:0]     status;
    wire [NOTE_KINDS-1:0][COUNT_WIDTH-1:0] stock_seen;

    queued_item_t  pending [$];
    note_result_t  expected_q [$];
    logic [COUNT_WIDTH-1:0] held [NOTE_KINDS] = '{default: '0};
    int            gap = 0;
    int            mismatches = 0;
    int            cycles = 0;

    note_dispenser_greedy_unit uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .cmd               (req_now.cmd),
        .amount            (req_now.amount),
        .deposit_count_100 (req_now.dep[0]),
        .deposit_count_50  (req_now.dep[1]),
        .deposit_count_20  (req_now.dep[2]),
        .deposit_count_10  (req_now.dep[3]),
        .deposit_count_5   (req_now.dep[4]),
        .deposit_count_2   (req_now.dep[5]),
        .deposit_count_1   (req_now.dep[6]),
        .done              (done),
        .status            (status),
        .stock_100         (stock_seen[0]),
        .stock_50          (stock_seen[1]),
        .stock_20          (stock_seen[2]),
        .stock_10          (stock_seen[3]),
        .stock_5           (stock_seen[4]),
        .stock_2           (stock_seen[5]),
        .stock_1           (stock_seen[6])
    );

    // greedy dispense or saturating deposit against the held stock
    function automatic note_result_t settle_item(input note_request_t rq);
        note_result_t           res;
        logic [COUNT_WIDTH-1:0] trial [NOTE_KINDS];
        longint unsigned        left;
        longint unsigned        fit;
        longint unsigned        take;
        longint unsigned        sum;
        bit                     sat;
        sat = 1'b0;
        if (rq.cmd == CMD_WITHDRAW)
        begin
            left = rq.amount;
            for (int k = 0; k < NOTE_KINDS; k++)
            begin
                fit = left / DENOM[k];
                take = (fit < held[k]) ? fit : held[k];
                trial[k] = held[k] - COUNT_WIDTH'(take);
                left -= take * DENOM[k];
            end
            if (left == 0)
            begin
                held = trial;
                res.status = STAT_WD_OK;
            end
            else
                res.status = STAT_WD_REFUSED;
        end
        else
        begin
            for (int k = 0; k < NOTE_KINDS; k++)
            begin
                sum = longint'(held[k]) + longint'(rq.dep[k]);
                if (sum > {COUNT_WIDTH{1'b1}})
                begin
                    sum = {COUNT_WIDTH{1'b1}};
                    sat = 1'b1;
                end
                held[k] = COUNT_WIDTH'(sum);
            end
            res.status = sat ? STAT_DEP_SAT : STAT_DEP_OK;
        end
        for (int k = 0; k < NOTE_KINDS; k++)
            res.stock[k] = held[k];
        return res;
    endfunction

    task automatic queue_item(input logic c, input logic [AMOUNT_WIDTH-1:0] a,
                              input note_counts_t d, input bit wait_empty, input bit calm);
        queued_item_t it;
        it.rq.cmd = c;
        it.rq.amount = a;
        it.rq.dep = d;
        it.wait_empty = wait_empty;
        it.calm = calm;
        pending.push_back(it);
    endtask

    function automatic note_counts_t random_counts(input int big_odds);
        note_counts_t d;
        for (int k = 0; k < NOTE_KINDS; k++)
            d[k] = ($urandom_range(0, big_odds - 1) == 0) ? COUNT_WIDTH'($urandom)
                                                          : COUNT_WIDTH'($urandom_range(0, 20));
        return d;
    endfunction

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $realtime, expected_q.size());
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin : drive
        bit           taken;
        queued_item_t nxt;
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            taken = start && !busy;
            if (taken)
                expected_q.push_back(settle_item(req_now));
            if (start && !taken)
            begin
                // hold the item until busy drops
            end
            else if (pending.size() == 0)
                start <= 1'b0;
            else if (gap != 0)
            begin
                gap--;
                start <= 1'b0;
            end
            else if (pending[0].wait_empty && expected_q.size() != 0)
                start <= 1'b0;
            else if (!pending[0].calm && $urandom_range(0, 5) == 0)
            begin
                // this cycle plus the remaining gap make an idle pause before the next item
                gap = $urandom_range(0, 16);
                start <= 1'b0;
            end
            else
            begin
                nxt = pending.pop_front();
                req_now <= nxt.rq;
                start <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : watch
        note_result_t want;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with no item waiting, status %0d", $realtime, status);
                mismatches++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $realtime, want.status, status);
                    mismatches++;
                end
                for (int k = 0; k < NOTE_KINDS; k++)
                    if (stock_seen[k] !== want.stock[k])
                    begin
                        $display("%0t: stock of %0d notes expected %0d actual %0d",
                                 $realtime, DENOM[k], want.stock[k], stock_seen[k]);
                        mismatches++;
                    end
            end
        end
    end

    initial
    begin : stimulus
        logic [AMOUNT_WIDTH-1:0] amt;
        int                      pick;
        bit                      calm;
        // empty stock: zero amount succeeds, anything else is refused
        queue_item(CMD_WITHDRAW, '0, '1, 1'b0, 1'b0);
        queue_item(CMD_WITHDRAW, 24'd1, '0, 1'b0, 1'b0);
        queue_item(CMD_WITHDRAW, '1, '1, 1'b0, 1'b0);
        queue_item(CMD_DEPOSIT, '1, '0, 1'b0, 1'b0);
        queue_item(CMD_DEPOSIT, '1, {NOTE_KINDS{16'd10}}, 1'b0, 1'b0);
        queue_item(CMD_WITHDRAW, 24'd188, '1, 1'b0, 1'b0);
        queue_item(CMD_WITHDRAW, 24'd3, '0, 1'b0, 1'b0);
        queue_item(CMD_WITHDRAW, 24'd1880, '0, 1'b0, 1'b0);
        queue_item(CMD_WITHDRAW, 24'd6, '0, 1'b0, 1'b0);
        queue_item(CMD_WITHDRAW, 24'd99, '0, 1'b0, 1'b0);
        queue_item(CMD_WITHDRAW, 24'd0, '1, 1'b0, 1'b0);
        // saturation on every count, then none, then on one count only
        queue_item(CMD_DEPOSIT, '0, '1, 1'b0, 1'b0);
        queue_item(CMD_DEPOSIT, '1, '0, 1'b0, 1'b0);
        queue_item(CMD_DEPOSIT, '0, {96'd0, 16'd1}, 1'b0, 1'b0);
        queue_item(CMD_WITHDRAW, '1, '0, 1'b0, 1'b0);
        queue_item(CMD_WITHDRAW, 24'd6553500, '0, 1'b0, 1'b0);
        queue_item(CMD_WITHDRAW, 24'd100, '0, 1'b0, 1'b0);
        queue_item(CMD_WITHDRAW, 24'd3276650, '0, 1'b0, 1'b0);
        queue_item(CMD_WITHDRAW, 24'd1966050, '0, 1'b0, 1'b0);
        queue_item(CMD_WITHDRAW, 24'd7, '0, 1'b0, 1'b0);
        queue_item(CMD_DEPOSIT, '1, {NOTE_KINDS{16'd3}}, 1'b0, 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = (i >= RANDOM_ITEMS - CALM_TAIL);
            pick = $urandom_range(0, 99);
            if (pick < 25)
                queue_item(CMD_DEPOSIT, AMOUNT_WIDTH'($urandom), random_counts(40),
                           (i == 0 || i == RANDOM_ITEMS / 2), calm);
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    amt = AMOUNT_WIDTH'($urandom_range(0, 1000));
                else if (pick < 8)
                    amt = AMOUNT_WIDTH'($urandom_range(0, 20));
                else if (pick < 9)
                    amt = AMOUNT_WIDTH'($urandom_range(0, 100000));
                else
                    amt = AMOUNT_WIDTH'($urandom);
                queue_item(CMD_WITHDRAW, amt, random_counts(1),
                           (i == 0 || i == RANDOM_ITEMS / 2), calm);
            end
        end

        wait (rst_n);
        while (pending.size() != 0 || start || expected_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
